// ===== src/sparse_signed_energy_sum_macros.svh =====
// Assertion macros shared by the sparse signed energy sum RTL.
`ifndef SPARSE_SIGNED_ENERGY_SUM_MACROS_SVH
`define SPARSE_SIGNED_ENERGY_SUM_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SSES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SSES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sses_pkg.sv =====
// Shared constants, types and state encodings for the sparse signed energy sum.
package sses_pkg;

  // Default table depth.
  localparam int MOLECULE_SLOTS = 1024;

  // Field and datapath widths.
  localparam int MOL_W      = 10;
  localparam int COEF_W     = 8;
  localparam int ENERGY_W   = 32;
  localparam int IDX_W      = 16;
  localparam int ACC_W      = 48;
  localparam int SCALE_W    = 32;
  localparam int PROD_W     = COEF_W + ENERGY_W;
  localparam int HALF_W     = ACC_W / 2;
  localparam int PP_W       = HALF_W + SCALE_W;
  localparam int MAG_W      = PP_W + 1;
  localparam int FRAC_SHIFT = 24;

  // Saturation limits of the Q31.16 accumulators and results.
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Input command codes.
  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_ENTRY = 1'b1
  } cmd_t;

  // Main control sequencer.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_EMIT
  } ctl_state_t;

  // Scaling unit sequencer.
  typedef enum logic [2:0] {
    SC_IDLE,
    SC_ABS,
    SC_MLO,
    SC_MHI,
    SC_SUM,
    SC_SAT
  } scl_state_t;

  // Controls from the sequencer to the accumulator unit.
  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic clear;
  } acc_ctrl_t;

endpackage

// ===== src/sses_energy_mem.sv =====
// Energy table: synchronous single-port-write, single-port-read memory.
module sses_energy_mem #(
  parameter int DEPTH = sses_pkg::MOLECULE_SLOTS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [ADDR_W-1:0]                 waddr,
  input  logic [sses_pkg::ENERGY_W-1:0]     wdata,
  input  logic                              re,
  input  logic [ADDR_W-1:0]                 raddr,
  output logic [sses_pkg::ENERGY_W-1:0]     rdata
);

  logic [sses_pkg::ENERGY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sses_accum.sv =====
// Coefficient times energy product and the two saturating accumulators.
module sses_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sses_pkg::acc_ctrl_t                   ctrl,
  input  logic signed [sses_pkg::COEF_W-1:0]    coef,
  input  logic                                  hit,
  input  logic signed [sses_pkg::ENERGY_W-1:0]  rd_data,
  output logic signed [sses_pkg::ACC_W-1:0]     fwd_acc,
  output logic signed [sses_pkg::ACC_W-1:0]     rev_acc
);

  logic signed [sses_pkg::PROD_W-1:0] prod;
  logic signed [sses_pkg::ACC_W:0]    fwd_sum;
  logic signed [sses_pkg::ACC_W:0]    rev_sum;

  // Clamp a sum that grew by one bit back to the accumulator range.
  function automatic logic signed [sses_pkg::ACC_W-1:0] sat_acc(
    input logic signed [sses_pkg::ACC_W:0] v
  );
    if (v[sses_pkg::ACC_W] != v[sses_pkg::ACC_W-1]) begin
      return v[sses_pkg::ACC_W] ? sses_pkg::ACC_MIN : sses_pkg::ACC_MAX;
    end
    return v[sses_pkg::ACC_W-1:0];
  endfunction

  // Product register; a lookup beyond the table reads as zero energy.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      if (hit) begin
        prod <= coef * rd_data;
      end else begin
        prod <= '0;
      end
    end
  end

  // Reactants add to the forward sum, products subtract from the reverse sum.
  assign fwd_sum = (sses_pkg::ACC_W+1)'(fwd_acc) + (sses_pkg::ACC_W+1)'(prod);
  assign rev_sum = (sses_pkg::ACC_W+1)'(rev_acc) - (sses_pkg::ACC_W+1)'(prod);

  // Accumulator registers.
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      fwd_acc <= '0;
      rev_acc <= '0;
    end else if (ctrl.acc_en) begin
      if (coef < 0) begin
        fwd_acc <= sat_acc(fwd_sum);
      end else if (coef > 0) begin
        rev_acc <= sat_acc(rev_sum);
      end
    end
  end

endmodule

// ===== src/sses_scaler.sv =====
// Multi-cycle scaling unit: both sums times -1/RT with rounding and saturation.
module sses_scaler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [sses_pkg::ACC_W-1:0]     fwd_acc,
  input  logic signed [sses_pkg::ACC_W-1:0]     rev_acc,
  input  logic signed [sses_pkg::SCALE_W-1:0]   scale,
  output logic                                  busy,
  output logic                                  done,
  output logic signed [sses_pkg::ACC_W-1:0]     fwd_rate,
  output logic signed [sses_pkg::ACC_W-1:0]     rev_rate
);

  localparam logic [sses_pkg::MAG_W-1:0] ROUND_HALF =
    sses_pkg::MAG_W'(1) << (sses_pkg::FRAC_SHIFT - 1);
  localparam logic [sses_pkg::MAG_W-1:0] POS_LIMIT =
    sses_pkg::MAG_W'(sses_pkg::ACC_MAX);
  localparam logic [sses_pkg::MAG_W-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

  sses_pkg::scl_state_t state, state_next;

  logic                               sel;
  logic [sses_pkg::ACC_W-1:0]         a_mag;
  logic [sses_pkg::SCALE_W-1:0]       s_mag;
  logic                               neg;
  logic [sses_pkg::PP_W-1:0]          pp_lo;
  logic [sses_pkg::PP_W-1:0]          pp_hi;
  logic [sses_pkg::MAG_W-1:0]         mag;
  logic signed [sses_pkg::ACC_W-1:0]  acc_sel;
  logic [sses_pkg::HALF_W-1:0]        a_part;
  logic [sses_pkg::PP_W-1:0]          mul_out;
  logic [sses_pkg::MAG_W-1:0]         lo_rnd;
  logic signed [sses_pkg::ACC_W-1:0]  sat_out;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sses_pkg::SC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state; the forward sum is scaled first, then the reverse sum.
  always_comb begin
    state_next = state;
    done       = 1'b0;
    busy       = (state != sses_pkg::SC_IDLE);
    unique case (state)
      sses_pkg::SC_IDLE: begin
        if (start) begin
          state_next = sses_pkg::SC_ABS;
        end
      end
      sses_pkg::SC_ABS: state_next = sses_pkg::SC_MLO;
      sses_pkg::SC_MLO: state_next = sses_pkg::SC_MHI;
      sses_pkg::SC_MHI: state_next = sses_pkg::SC_SUM;
      sses_pkg::SC_SUM: state_next = sses_pkg::SC_SAT;
      sses_pkg::SC_SAT: begin
        if (sel) begin
          state_next = sses_pkg::SC_IDLE;
          done       = 1'b1;
        end else begin
          state_next = sses_pkg::SC_ABS;
        end
      end
      default: state_next = sses_pkg::SC_IDLE;
    endcase
  end

  // Operand select and the one shared 24 by 32 bit multiplier.
  assign acc_sel = sel ? rev_acc : fwd_acc;
  assign a_part  = (state == sses_pkg::SC_MHI) ? a_mag[sses_pkg::ACC_W-1:sses_pkg::HALF_W]
                                                : a_mag[sses_pkg::HALF_W-1:0];
  assign mul_out = a_part * s_mag;

  // Low partial product rounded at the binary point, ties away from zero.
  assign lo_rnd = ({1'b0, pp_lo} + ROUND_HALF) >> sses_pkg::FRAC_SHIFT;

  // Apply the sign and clamp to the 48-bit result range.
  always_comb begin
    if (neg) begin
      if (mag > NEG_LIMIT) begin
        sat_out = sses_pkg::ACC_MIN;
      end else begin
        sat_out = sses_pkg::ACC_W'(-mag);
      end
    end else begin
      if (mag > POS_LIMIT) begin
        sat_out = sses_pkg::ACC_MAX;
      end else begin
        sat_out = mag[sses_pkg::ACC_W-1:0];
      end
    end
  end

  // Operand select bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (state == sses_pkg::SC_SAT) begin
      sel <= ~sel;
    end
  end

  // Datapath registers, one step per state.
  always_ff @(posedge clk) begin
    case (state)
      sses_pkg::SC_ABS: begin
        a_mag <= acc_sel[sses_pkg::ACC_W-1] ? sses_pkg::ACC_W'(-acc_sel) : acc_sel;
        s_mag <= scale[sses_pkg::SCALE_W-1] ? sses_pkg::SCALE_W'(-scale) : scale;
        neg   <= acc_sel[sses_pkg::ACC_W-1] ^ scale[sses_pkg::SCALE_W-1];
      end
      sses_pkg::SC_MLO: pp_lo <= mul_out;
      sses_pkg::SC_MHI: pp_hi <= mul_out;
      sses_pkg::SC_SUM: mag   <= {1'b0, pp_hi} + lo_rnd;
      sses_pkg::SC_SAT: begin
        if (sel) begin
          rev_rate <= sat_out;
        end else begin
          fwd_rate <= sat_out;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== src/sparse_signed_energy_sum.sv =====
// Top level of the sparse signed energy sum: sequencer, config and output register.
//
// Usage. The input channel (in_valid/in_ready) carries one word per item.
// With cmd at load the energy word is written to table slot molecule
// (slots beyond the table are ignored). With cmd at entry the slot is
// looked up and coefficient times energy goes to the forward sum
// (negative coefficient) or off the reverse sum (positive).
// An entry passes through table read, multiply and accumulate, in order.
// An entry with last_of_reaction set then runs the scaling unit, which
// forms two partial products per sum through one 24 by 32 multiplier,
// and the result word is loaded into the output register.
// The next input word can be taken once the result word is loaded.
// The output channel (out_valid/out_ready) holds that word until taken;
// new items are accepted meanwhile, and only the next result waits for it.
// The config channel (cfg_valid/cfg_ready) writes -1/RT in Q7.24 and is
// always ready; write it only while the block is idle.
// Reset clears the sums, the reaction counter, the scale and the output
// valid flag. The energy table is not cleared and holds garbage until loaded.
`include "sparse_signed_energy_sum_macros.svh"

module sparse_signed_energy_sum #(
  parameter int MOLECULE_SLOTS = sses_pkg::MOLECULE_SLOTS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic signed [sses_pkg::SCALE_W-1:0]   cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic [sses_pkg::MOL_W-1:0]            molecule,
  input  logic signed [sses_pkg::COEF_W-1:0]    coefficient,
  input  logic signed [sses_pkg::ENERGY_W-1:0]  energy,
  input  logic                                  last_of_reaction,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sses_pkg::IDX_W-1:0]            reaction_index,
  output logic signed [sses_pkg::ACC_W-1:0]     log_forward_rate,
  output logic signed [sses_pkg::ACC_W-1:0]     log_reverse_rate
);

  localparam int ADDR_W = $clog2(MOLECULE_SLOTS);
  localparam int CMP_W  = ((ADDR_W > sses_pkg::MOL_W) ? ADDR_W : sses_pkg::MOL_W) + 1;

  sses_pkg::ctl_state_t state, state_next;
  sses_pkg::acc_ctrl_t  ctrl;

  logic signed [sses_pkg::SCALE_W-1:0]  neg_recip_rt;
  logic signed [sses_pkg::COEF_W-1:0]   coef_q;
  logic                                 last_q;
  logic                                 hit_q;
  logic [sses_pkg::IDX_W-1:0]           reaction_counter;
  logic [CMP_W-1:0]                     mol_ext;
  logic                                 hit;
  logic                                 accept;
  logic                                 scl_start;
  logic                                 scl_busy;
  logic                                 scl_done;
  logic                                 out_load;
  logic [sses_pkg::ENERGY_W-1:0]        rd_data;
  logic signed [sses_pkg::ACC_W-1:0]    fwd_acc;
  logic signed [sses_pkg::ACC_W-1:0]    rev_acc;
  logic signed [sses_pkg::ACC_W-1:0]    fwd_rate;
  logic signed [sses_pkg::ACC_W-1:0]    rev_rate;

  // Address decode: slots at or beyond the table depth miss.
  assign mol_ext = CMP_W'(molecule);
  assign hit     = (mol_ext < CMP_W'(MOLECULE_SLOTS));
  assign accept  = in_valid && in_ready;

  // Config register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neg_recip_rt <= '0;
    end else if (cfg_valid && cfg_ready) begin
      neg_recip_rt <= cfg_data;
    end
  end

  // Energy table.
  sses_energy_mem #(
    .DEPTH (MOLECULE_SLOTS)
  ) u_mem (
    .clk   (clk),
    .we    (accept && (cmd == sses_pkg::CMD_LOAD) && hit),
    .waddr (mol_ext[ADDR_W-1:0]),
    .wdata (energy),
    .re    (accept && (cmd == sses_pkg::CMD_ENTRY)),
    .raddr (mol_ext[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // Per-entry fields held while the entry is in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      coef_q <= coefficient;
      last_q <= last_of_reaction;
      hit_q  <= hit;
    end
  end

  // Product and accumulators.
  sses_accum u_accum (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .coef    (coef_q),
    .hit     (hit_q),
    .rd_data (rd_data),
    .fwd_acc (fwd_acc),
    .rev_acc (rev_acc)
  );

  // Scaling unit.
  sses_scaler u_scaler (
    .clk      (clk),
    .rst      (rst),
    .start    (scl_start),
    .fwd_acc  (fwd_acc),
    .rev_acc  (rev_acc),
    .scale    (neg_recip_rt),
    .busy     (scl_busy),
    .done     (scl_done),
    .fwd_rate (fwd_rate),
    .rev_rate (rev_rate)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sses_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and controls.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    ctrl        = '0;
    scl_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      sses_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (accept && (cmd == sses_pkg::CMD_ENTRY)) begin
          state_next = sses_pkg::ST_MUL;
        end
      end
      sses_pkg::ST_MUL: begin
        ctrl.mul_en = 1'b1;
        state_next  = sses_pkg::ST_ACC;
      end
      sses_pkg::ST_ACC: begin
        ctrl.acc_en = 1'b1;
        if (last_q) begin
          scl_start  = 1'b1;
          state_next = sses_pkg::ST_SCALE;
        end else begin
          state_next = sses_pkg::ST_IDLE;
        end
      end
      sses_pkg::ST_SCALE: begin
        if (scl_done) begin
          state_next = sses_pkg::ST_EMIT;
        end
      end
      sses_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          ctrl.clear = 1'b1;
          state_next = sses_pkg::ST_IDLE;
        end
      end
      default: state_next = sses_pkg::ST_IDLE;
    endcase
  end

  // Reaction counter advances with each result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      reaction_counter <= '0;
    end else if (out_load) begin
      reaction_counter <= reaction_counter + 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      reaction_index   <= reaction_counter;
      log_forward_rate <= fwd_rate;
      log_reverse_rate <= rev_rate;
    end
  end

  // Checks on the sequencing.
  `SSES_ASSERT_IMP(a_ready_not_scaling, clk, rst, in_ready, !scl_busy, "input ready while scaling")
  `SSES_ASSERT_IMP(a_done_in_scale, clk, rst, scl_done,
                   state == sses_pkg::ST_SCALE, "stray scaler done")
  `SSES_ASSERT_NEXT(a_clear_after_emit, clk, rst, out_load,
                    (fwd_acc == '0) && (rev_acc == '0), "sums not cleared")
  `SSES_ASSERT_NEXT(a_count_step, clk, rst, out_load,
                    reaction_counter == $past(reaction_counter) + 16'd1, "counter slip")

endmodule

// ===== sim/sparse_signed_energy_sum_tb.sv =====
// Self-checking testbench for the sparse signed energy sum block.
`timescale 1ns / 100ps

module sparse_signed_energy_sum_tb;

  // Width of the exact sum times scale product.
  localparam int WIDE_W = sses_pkg::ACC_W + sses_pkg::SCALE_W + 1;

  // One word on the input channel.
  typedef struct packed {
    sses_pkg::cmd_t                       cmd;
    logic [sses_pkg::MOL_W-1:0]           mol;
    logic signed [sses_pkg::COEF_W-1:0]   coef;
    logic signed [sses_pkg::ENERGY_W-1:0] energy;
    logic                                 ends;
  } word_t;

  // One expected reaction result.
  typedef struct packed {
    logic [sses_pkg::IDX_W-1:0]        idx;
    logic signed [sses_pkg::ACC_W-1:0] fwd;
    logic signed [sses_pkg::ACC_W-1:0] rev;
  } rates_t;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic signed [sses_pkg::SCALE_W-1:0]  cfg_data = '0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic                                 cmd = 1'b0;
  logic [sses_pkg::MOL_W-1:0]           molecule = '0;
  logic signed [sses_pkg::COEF_W-1:0]   coefficient = '0;
  logic signed [sses_pkg::ENERGY_W-1:0] energy = '0;
  logic                                 last_of_reaction = 1'b0;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [sses_pkg::IDX_W-1:0]           reaction_index;
  logic signed [sses_pkg::ACC_W-1:0]    log_forward_rate;
  logic signed [sses_pkg::ACC_W-1:0]    log_reverse_rate;

  // Stimulus queue, expected results and bookkeeping.
  word_t  word_q[$];
  rates_t rate_q[$];
  word_t  on_bus;
  int     words_queued = 0;
  int     words_taken = 0;
  int     mismatches = 0;
  int     idle_pct = 19;
  int     known_mol[$];
  bit     is_known[sses_pkg::MOLECULE_SLOTS];

  // Shadow state of the block.
  logic signed [sses_pkg::ENERGY_W-1:0] energy_mem[sses_pkg::MOLECULE_SLOTS];
  logic signed [sses_pkg::ACC_W-1:0]    fwd_sum = '0;
  logic signed [sses_pkg::ACC_W-1:0]    rev_sum = '0;
  logic [sses_pkg::IDX_W-1:0]           next_index = '0;
  logic signed [sses_pkg::SCALE_W-1:0]  scale_reg = '0;

  sparse_signed_energy_sum u_top (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .molecule         (molecule),
    .coefficient      (coefficient),
    .energy           (energy),
    .last_of_reaction (last_of_reaction),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .reaction_index   (reaction_index),
    .log_forward_rate (log_forward_rate),
    .log_reverse_rate (log_reverse_rate)
  );

  always #6 clk = ~clk;

  // Add a product to a sum, saturating to the 48-bit range.
  function automatic logic signed [sses_pkg::ACC_W-1:0] clamp_sum(
    input logic signed [sses_pkg::ACC_W-1:0] acc,
    input logic signed [sses_pkg::PROD_W:0]  delta
  );
    logic signed [sses_pkg::ACC_W+1:0] s;
    s = acc + delta;
    if (s > sses_pkg::ACC_MAX) return sses_pkg::ACC_MAX;
    if (s < sses_pkg::ACC_MIN) return sses_pkg::ACC_MIN;
    return s[sses_pkg::ACC_W-1:0];
  endfunction

  // Multiply a Q31.16 sum by the Q7.24 scale, round half away from zero, saturate.
  function automatic logic signed [sses_pkg::ACC_W-1:0] log_rate(
    input logic signed [sses_pkg::ACC_W-1:0]   acc,
    input logic signed [sses_pkg::SCALE_W-1:0] sc
  );
    logic signed [WIDE_W-1:0] prod;
    logic [WIDE_W-1:0]        mag;
    logic                     neg;
    prod = acc * sc;
    neg = (prod < 0);
    mag = neg ? -prod : prod;
    mag = (mag + (WIDE_W'(1) << (sses_pkg::FRAC_SHIFT - 1))) >> sses_pkg::FRAC_SHIFT;
    if (neg) begin
      if (mag > (WIDE_W'(1) << (sses_pkg::ACC_W - 1))) return sses_pkg::ACC_MIN;
      return sses_pkg::ACC_W'(0) - mag[sses_pkg::ACC_W-1:0];
    end
    if (mag > sses_pkg::ACC_MAX) return sses_pkg::ACC_MAX;
    return mag[sses_pkg::ACC_W-1:0];
  endfunction

  // Apply one accepted word to the shadow state; a closing entry yields a result.
  task automatic absorb_word(input word_t w);
    logic signed [sses_pkg::PROD_W:0] prod;
    if (w.cmd == sses_pkg::CMD_LOAD) begin
      energy_mem[w.mol] = w.energy;
    end else begin
      if (w.coef != 0) begin
        prod = w.coef * energy_mem[w.mol];
        if (w.coef < 0) fwd_sum = clamp_sum(fwd_sum, prod);
        else rev_sum = clamp_sum(rev_sum, -prod);
      end
      if (w.ends) begin
        rate_q.push_back('{next_index, log_rate(fwd_sum, scale_reg),
                           log_rate(rev_sum, scale_reg)});
        next_index = next_index + 1'b1;
        fwd_sum = '0;
        rev_sum = '0;
      end
    end
  endtask

  // Driver: present queued words, with random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(on_bus);
        words_taken++;
      end
      if (!in_valid || in_ready) begin
        if (word_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          on_bus = word_q.pop_front();
          in_valid <= 1'b1;
          cmd <= on_bus.cmd;
          molecule <= on_bus.mol;
          coefficient <= on_bus.coef;
          energy <= on_bus.energy;
          last_of_reaction <= on_bus.ends;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Report one field that differs from its expected value.
  task automatic compare_field(input string what, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Monitor: take results with random stalls and check them in order.
  always @(posedge clk) begin
    rates_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (rate_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got index %0d", $time,
                   reaction_index);
        end else begin
          want = rate_q.pop_front();
          compare_field("reaction_index", 64'(want.idx), 64'(reaction_index));
          compare_field("log_forward_rate", 64'(want.fwd), 64'(log_forward_rate));
          compare_field("log_reverse_rate", 64'(want.rev), 64'(log_reverse_rate));
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Queue one word; remember which table slots hold a value.
  task automatic push_word(input sses_pkg::cmd_t c, input int mol, input int coef,
                           input int en, input bit ends);
    word_q.push_back('{c, sses_pkg::MOL_W'(mol), sses_pkg::COEF_W'(coef),
                       sses_pkg::ENERGY_W'(en), ends});
    words_queued++;
    if (c == sses_pkg::CMD_LOAD && !is_known[mol]) begin
      is_known[mol] = 1'b1;
      known_mol.push_back(mol);
    end
  endtask

  // Queue a table load with a random slot, a spread of energies and junk in the unused fields.
  task automatic push_load();
    int mol;
    int en;
    case ($urandom_range(9))
      0: mol = 0;
      1: mol = sses_pkg::MOLECULE_SLOTS - 1;
      default: mol = $urandom_range(sses_pkg::MOLECULE_SLOTS - 1);
    endcase
    case ($urandom_range(9))
      0, 1: en = 32'h7FFF_FFFF;
      2, 3: en = 32'h8000_0000;
      4, 5, 6: en = int'($urandom_range(16)) - 8;
      7: en = ($urandom_range(1) != 0) ? 32'h0001_0000 : 32'hFFFF_0000;
      default: en = $urandom;
    endcase
    push_word(sses_pkg::CMD_LOAD, mol, $urandom, en, 1'($urandom_range(1)));
  endtask

  // Random traffic: loads, reactions of mixed length, and loads inside reactions.
  task automatic queue_random_traffic(input int count);
    int made;
    int len;
    int coef;
    made = 0;
    while (made < count) begin
      if ($urandom_range(99) < 12) begin
        push_load();
        made++;
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(6, 1);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(19) == 0) begin
            push_load();
            made++;
          end
          case ($urandom_range(9))
            0: coef = -128;
            1: coef = 127;
            2: coef = 0;
            3: coef = -1;
            4: coef = 1;
            5, 6: coef = int'($urandom_range(8)) - 4;
            default: coef = $urandom;
          endcase
          push_word(sses_pkg::CMD_ENTRY, known_mol[$urandom_range(known_mol.size() - 1)],
                    coef, $urandom, j == len - 1);
          made++;
        end
      end
    end
  endtask

  // Hold off until every queued word is taken and every result has come, then let it drain.
  task automatic settle();
    while (words_taken != words_queued || rate_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Write the scale register while the block is idle.
  task automatic write_scale(input logic signed [sses_pkg::SCALE_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    scale_reg = v;
  endtask

  // Stimulus sequence.
  initial begin
    logic signed [sses_pkg::SCALE_W-1:0] scales[6];
    scales = '{32'h8000_0000, 32'hFF00_0000, 32'h0080_0000, 32'h7FFF_FFFF,
               32'h0000_0000, 32'h0000_0000};
    scales[4] = $urandom;
    scales[5] = -int'($urandom_range(1 << 26, 1 << 20));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Table extremes; a load carrying junk coefficient and last flag.
    push_word(sses_pkg::CMD_LOAD, 0, 0, 32'h7FFF_FFFF, 1'b0);
    push_word(sses_pkg::CMD_LOAD, sses_pkg::MOLECULE_SLOTS - 1, 0, 32'h8000_0000, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 1, 0, 32'h0001_0000, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 2, 0, 32'hFFFF_FFFF, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 3, 0, 1, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 512, 0, 32'h1234_5678, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 4, -128, 32'hFFFF_0000, 1'b1);
    // Reaction under the reset scale of zero.
    push_word(sses_pkg::CMD_ENTRY, 1, -3, 0, 1'b1);

    write_scale(32'h0100_0000);
    // Empty reaction, then every coefficient extreme against both energy extremes.
    push_word(sses_pkg::CMD_ENTRY, 0, 0, 32'h5A5A_5A5A, 1'b1);
    push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, -128, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 0, 127, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 0, -128, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, 127, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 3, 0, 32'hFFFF_FFFF, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 2, -1, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 3, 1, 0, 1'b1);
    // A load in the middle of a reaction is seen by the entry after it.
    push_word(sses_pkg::CMD_ENTRY, 512, 5, 0, 1'b0);
    push_word(sses_pkg::CMD_LOAD, 5, 0, 32'h0007_0000, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 5, -5, 0, 1'b1);

    // Half scale on sums of one LSB: both rounding ties.
    write_scale(32'h0080_0000);
    push_word(sses_pkg::CMD_ENTRY, 2, -1, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 3, 1, 0, 1'b1);

    // Most negative scale on a large forward sum: the result saturates.
    write_scale(32'h8000_0000);
    repeat (5) push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, -128, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, 127, 0, 1'b1);

    // Drive both sums into saturation with no gaps or stalls, then back them off.
    write_scale(32'h0100_0000);
    idle_pct = 0;
    for (int i = 0; i < 1040; i++) begin
      if (i % 2 == 0) begin
        push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, -128, $urandom, 1'b0);
      end else begin
        push_word(sses_pkg::CMD_ENTRY, 0, 127, $urandom, 1'b0);
      end
    end
    push_word(sses_pkg::CMD_ENTRY, 0, -128, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, 127, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, 0, -7, 0, 1'b0);
    push_word(sses_pkg::CMD_ENTRY, sses_pkg::MOLECULE_SLOTS - 1, 3, 0, 1'b1);

    // Random traffic under a range of scales; one phase runs without gaps.
    for (int p = 0; p < 6; p++) begin
      write_scale(scales[p]);
      idle_pct = (p == 3) ? 0 : 19;
      queue_random_traffic(14);
    end

    settle();
    if (mismatches == 0) begin
      $display("sparse_signed_energy_sum_tb: done, clean");
    end else begin
      $display("sparse_signed_energy_sum_tb: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("sparse_signed_energy_sum_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sses_pkg.sv
src/sses_energy_mem.sv
src/sses_accum.sv
src/sses_scaler.sv
src/sparse_signed_energy_sum.sv
sim/sparse_signed_energy_sum_tb.sv
